// ===== rtl/srv_pkg.sv =====
package srv_pkg;

	localparam int MAX_REQUEST = 256;
	localparam int BCNT_W      = $clog2(MAX_REQUEST + 1);
	localparam int TLEN_W      = 9;
	localparam int TIDX_W      = 3;
	localparam int TIDX_MAX    = 5;
	localparam int CMD_LEN     = 3;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;
	localparam int HOST_SFX    = 6;
	localparam int ONION_LEN   = 5;

	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_DOT   = 8'h2e;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_VER,
		CMD_MSG,
		CMD_RCP,
		CMD_ACK
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_VERSION,
		ST_TOO_LONG,
		ST_BAD_FORMAT
	} status_t;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_MSGID,
		KIND_HOST,
		KIND_USER,
		KIND_HASH
	} kind_t;

	typedef enum logic [1:0] {
		REG_MSGID_LEN,
		REG_HOST_LEN,
		REG_USER_LEN,
		REG_HASH_LEN
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] msgid_len;
		logic [7:0] host_len;
		logic [7:0] user_len;
		logic [7:0] hash_len;
	} cfg_t;

	// classified request byte as it travels through the queue
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       slash;
		logic       hex;
		logic       b32;
		cmd_t       first_cmd;
	} word_t;

	function automatic logic [7:0] cmd_name_char(cmd_t cmd, logic [1:0] p);
		logic [7:0] r;
		r = 8'h00;
		unique case (cmd)
			CMD_VER: begin
				unique case (p)
					2'd0: r = "v";
					2'd1: r = "e";
					2'd2: r = "r";
					default: r = 8'h00;
				endcase
			end
			CMD_MSG: begin
				unique case (p)
					2'd0: r = "m";
					2'd1: r = "s";
					2'd2: r = "g";
					default: r = 8'h00;
				endcase
			end
			CMD_RCP: begin
				unique case (p)
					2'd0: r = "r";
					2'd1: r = "c";
					2'd2: r = "p";
					default: r = 8'h00;
				endcase
			end
			CMD_ACK: begin
				unique case (p)
					2'd0: r = "a";
					2'd1: r = "c";
					2'd2: r = "k";
					default: r = 8'h00;
				endcase
			end
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] onion_char(logic [2:0] i);
		logic [7:0] r;
		unique case (i)
			3'd0: r = "o";
			3'd1: r = "n";
			3'd2: r = "i";
			3'd3: r = "o";
			3'd4: r = "n";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic kind_t token_kind(logic [TIDX_W-1:0] pos, cmd_t cmd);
		kind_t k;
		k = KIND_NONE;
		if (pos == TIDX_W'(1) && (cmd == CMD_MSG || cmd == CMD_RCP || cmd == CMD_ACK))
			k = KIND_MSGID;
		else if (pos == TIDX_W'(2) && cmd == CMD_MSG)
			k = KIND_HOST;
		else if (pos == TIDX_W'(2) && cmd == CMD_ACK)
			k = KIND_HASH;
		else if (pos == TIDX_W'(3) && cmd == CMD_MSG)
			k = KIND_USER;
		return k;
	endfunction

	function automatic logic [TLEN_W-1:0] kind_len(kind_t k, cfg_t cfg);
		logic [TLEN_W-1:0] r;
		unique case (k)
			KIND_MSGID: r = TLEN_W'(cfg.msgid_len);
			KIND_HOST:  r = TLEN_W'(cfg.host_len) + TLEN_W'(HOST_SFX);
			KIND_USER:  r = TLEN_W'(cfg.user_len);
			KIND_HASH:  r = TLEN_W'(cfg.hash_len);
			default:    r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [TIDX_W-1:0] tokens_needed(cmd_t cmd);
		logic [TIDX_W-1:0] r;
		unique case (cmd)
			CMD_VER: r = TIDX_W'(1);
			CMD_MSG: r = TIDX_W'(4);
			CMD_RCP: r = TIDX_W'(2);
			CMD_ACK: r = TIDX_W'(3);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/srv_if.sv =====
interface srv_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] req_byte;
	logic       is_last;

	modport source(output valid, output req_byte, output is_last, input ready);
	modport sink(input valid, input req_byte, input is_last, output ready);
endinterface

interface srv_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [2:0] command;

	modport source(output valid, output status, output command, input ready);
	modport sink(input valid, input status, input command, output ready);
endinterface

// ===== rtl/slash_request_validator.sv =====
// Request path validator: bytes of a '/'-separated path stream in on req, one
// word per cycle at full rate, and after the word marked is_last one result
// (status, command) comes out on res. The front end classifies each byte and
// writes it into a 4-word queue; the back end takes one word per cycle from
// the queue and updates the token counters, so a result leaves in the cycle after
// its last byte is taken from the queue. A stalled res holds the back end while
// the front keeps accepting until the queue is full. Registers at byte address
// 4*i: msgid_len, host_len, user_len, hash_len (low 8 bits of pwdata); write
// them only while no request is in flight.
module slash_request_validator
	import srv_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	srv_req_if.sink            req,
	srv_res_if.source          res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;
	logic [7:0] rd_val;

	logic  q_full;
	logic  q_push;
	word_t q_in_word;
	logic  q_pop;
	logic  q_valid;
	word_t q_out_word;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.msgid_len <= 8'd40;
			cfg_q.host_len  <= 8'd16;
			cfg_q.user_len  <= 8'd32;
			cfg_q.hash_len  <= 8'd128;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_MSGID_LEN: cfg_q.msgid_len <= pwdata[7:0];
				REG_HOST_LEN:  cfg_q.host_len  <= pwdata[7:0];
				REG_USER_LEN:  cfg_q.user_len  <= pwdata[7:0];
				REG_HASH_LEN:  cfg_q.hash_len  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MSGID_LEN: rd_val = cfg_q.msgid_len;
			REG_HOST_LEN:  rd_val = cfg_q.host_len;
			REG_USER_LEN:  rd_val = cfg_q.user_len;
			REG_HASH_LEN:  rd_val = cfg_q.hash_len;
			default:       rd_val = 8'h00;
		endcase
	end

	assign prdata = PDATA_W'(rd_val);

	srv_front u_front (
		.req    (req),
		.q_full (q_full),
		.q_push (q_push),
		.q_word (q_in_word)
	);

	srv_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (q_in_word),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_word  (q_out_word)
	);

	srv_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_word  (q_out_word),
		.q_pop   (q_pop),
		.res     (res)
	);

endmodule

// ===== rtl/srv_front.sv =====
module srv_front
	import srv_pkg::*;
(
	srv_req_if.sink req,
	input  logic    q_full,
	output logic    q_push,
	output word_t   q_word
);

	logic [7:0] c;

	assign c         = req.req_byte;
	assign req.ready = !q_full;
	assign q_push    = req.valid && !q_full;

	always_comb begin
		q_word.ch    = c;
		q_word.last  = req.is_last;
		q_word.slash = (c == CH_SLASH);
		q_word.hex   = (c >= "0" && c <= "9") || (c >= "a" && c <= "f");
		q_word.b32   = (c >= "a" && c <= "z") || (c >= "2" && c <= "7");
		// command guess from the first letter of a token
		unique case (c)
			"v":     q_word.first_cmd = CMD_VER;
			"m":     q_word.first_cmd = CMD_MSG;
			"r":     q_word.first_cmd = CMD_RCP;
			"a":     q_word.first_cmd = CMD_ACK;
			default: q_word.first_cmd = CMD_NONE;
		endcase
	end

endmodule

// ===== rtl/srv_fifo.sv =====
module srv_fifo
	import srv_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  word_t push_word,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output word_t pop_word
);

	word_t             mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_word  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= push_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + QCNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

// ===== rtl/srv_back.sv =====
module srv_back
	import srv_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    q_valid,
	input  word_t   q_word,
	output logic    q_pop,
	srv_res_if.source res
);

	logic [BCNT_W-1:0] bcnt_q, bcnt_n;
	logic [TIDX_W-1:0] tidx_q, tidx_n;
	logic [TLEN_W-1:0] tlen_q, tlen_n;
	logic              inside_q, inside_n;
	cmd_t              cmd_q, cmd_n;
	logic              ok_q, ok_n;
	logic              bad_q, bad_n;
	logic              long_q, long_n;

	logic              res_valid_q;
	status_t           status_q, status_n;
	cmd_t              res_cmd_q, res_cmd_n;

	logic [TIDX_W-1:0] pos;
	logic [TLEN_W-1:0] p;
	logic [TLEN_W-1:0] host_w;
	logic [TLEN_W-1:0] hoff;
	kind_t             kind;
	kind_t             ekind;
	logic              fits;

	assign q_pop       = q_valid && (!res_valid_q || res.ready);
	assign res.valid   = res_valid_q;
	assign res.status  = status_q;
	assign res.command = res_cmd_q;

	assign host_w = TLEN_W'(cfg.host_len);
	assign hoff   = p - host_w - TLEN_W'(1);

	always_comb begin
		bcnt_n   = bcnt_q;
		long_n   = long_q;
		tidx_n   = tidx_q;
		tlen_n   = tlen_q;
		inside_n = inside_q;
		cmd_n    = cmd_q;
		ok_n     = ok_q;
		bad_n    = bad_q;
		pos      = '0;
		p        = '0;
		kind     = KIND_NONE;
		ekind    = KIND_NONE;
		fits     = 1'b1;
		status_n = ST_BAD_FORMAT;
		res_cmd_n = CMD_NONE;

		if (bcnt_q >= BCNT_W'(MAX_REQUEST))
			long_n = 1'b1;
		else
			bcnt_n = bcnt_q + BCNT_W'(1);

		if (!q_word.slash) begin
			if (!inside_q) begin
				inside_n = 1'b1;
				tlen_n   = '0;
				ok_n     = 1'b1;
				if (tidx_q < TIDX_W'(TIDX_MAX))
					tidx_n = tidx_q + TIDX_W'(1);
			end
			pos = tidx_n - TIDX_W'(1);
			p   = tlen_n;
			if (pos == '0) begin
				if (p == '0)
					cmd_n = q_word.first_cmd;
				else if (p < TLEN_W'(CMD_LEN)) begin
					if (cmd_q == CMD_NONE || q_word.ch != cmd_name_char(cmd_q, p[1:0]))
						cmd_n = CMD_NONE;
				end else
					cmd_n = CMD_NONE;
			end else begin
				kind = token_kind(pos, cmd_q);
				unique case (kind)
					KIND_MSGID, KIND_HASH: fits = q_word.hex;
					KIND_USER:             fits = q_word.b32;
					KIND_HOST: begin
						if (p < host_w)
							fits = q_word.b32;
						else if (p == host_w)
							fits = (q_word.ch == CH_DOT);
						else if (hoff < TLEN_W'(ONION_LEN))
							fits = (q_word.ch == onion_char(hoff[2:0]));
						else
							fits = 1'b0;
					end
					default: fits = 1'b1;
				endcase
				if (kind != KIND_NONE && !fits)
					ok_n = 1'b0;
			end
			if (tlen_n != '1)
				tlen_n = tlen_n + TLEN_W'(1);
		end

		// token closes on a slash or at the end of the request
		if (inside_n && (q_word.slash || q_word.last)) begin
			if (tidx_n == TIDX_W'(1)) begin
				if (tlen_n != TLEN_W'(CMD_LEN))
					cmd_n = CMD_NONE;
			end else begin
				ekind = token_kind(tidx_n - TIDX_W'(1), cmd_n);
				if (ekind != KIND_NONE && (!ok_n || tlen_n != kind_len(ekind, cfg)))
					bad_n = 1'b1;
			end
			inside_n = 1'b0;
		end

		priority if (long_n) begin
			status_n  = ST_TOO_LONG;
			res_cmd_n = CMD_NONE;
		end else if (tidx_n == '0 || cmd_n == CMD_NONE) begin
			status_n  = ST_BAD_FORMAT;
			res_cmd_n = CMD_NONE;
		end else begin
			res_cmd_n = cmd_n;
			if (tidx_n != tokens_needed(cmd_n) || bad_n)
				status_n = ST_BAD_FORMAT;
			else if (cmd_n == CMD_VER)
				status_n = ST_VERSION;
			else
				status_n = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q      <= '0;
			tidx_q      <= '0;
			tlen_q      <= '0;
			inside_q    <= 1'b0;
			cmd_q       <= CMD_NONE;
			ok_q        <= 1'b1;
			bad_q       <= 1'b0;
			long_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (q_pop && q_word.last)
				res_valid_q <= 1'b1;
			else if (res_valid_q && res.ready)
				res_valid_q <= 1'b0;
			if (q_pop) begin
				if (q_word.last) begin
					bcnt_q   <= '0;
					tidx_q   <= '0;
					tlen_q   <= '0;
					inside_q <= 1'b0;
					cmd_q    <= CMD_NONE;
					ok_q     <= 1'b1;
					bad_q    <= 1'b0;
					long_q   <= 1'b0;
				end else begin
					bcnt_q   <= bcnt_n;
					tidx_q   <= tidx_n;
					tlen_q   <= tlen_n;
					inside_q <= inside_n;
					cmd_q    <= cmd_n;
					ok_q     <= ok_n;
					bad_q    <= bad_n;
					long_q   <= long_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_word.last) begin
			status_q  <= status_n;
			res_cmd_q <= res_cmd_n;
		end
	end

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_word.last |=> res_valid_q)
		else $error("last word popped without a result");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_word.last |=> bcnt_q == '0 && tidx_q == '0 && !inside_q)
		else $error("request state not cleared after last word");

	a_inside_has_token: assert property (@(posedge clk) disable iff (!arst_n)
		inside_q |-> tidx_q != '0 && tlen_q != '0)
		else $error("inside a token with no token begun");

	a_no_pop_over_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res.ready |-> !q_pop)
		else $error("word popped while result stalled");

endmodule
